FILE: rtl/ffha_pkg.sv
// Shared types, constants and helpers of the first-fit heap allocator.
// Depends on nothing; used by the allocator core, its checker and its testbench.
package ffha_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int LINK_W     = $clog2(NODE_COUNT + 1);
  localparam int BOUND      = 2 * NODE_COUNT + 2;
  localparam int STEP_W     = $clog2(BOUND + 1);
  localparam int OFF_W      = 28;
  localparam int UNITS_W    = 26;

  localparam logic [UNITS_W-1:0] MAX_UNITS = {UNITS_W{1'b1}};
  localparam logic [LINK_W-1:0]  SENTINEL  = LINK_W'(NODE_COUNT);

  // status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_FIT       = 3'd1;
  localparam logic [2:0] ST_NO_SLOT      = 3'd2;
  localparam logic [2:0] ST_BELOW_BASE   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd4;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd5;

  // one entry of the node table
  typedef struct packed {
    logic [OFF_W-1:0]   offset;
    logic               is_free;
    logic [UNITS_W-1:0] units;
    logic [LINK_W-1:0]  link;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // clamp a link to the end-of-list mark
  function automatic logic [LINK_W-1:0] next_of(input logic [LINK_W-1:0] link);
    return (link >= SENTINEL) ? SENTINEL : link;
  endfunction

endpackage

FILE: rtl/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator core: node table in one RAM, list walks by a sequencer.
// Depends on ffha_pkg and ffha_ram.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  request  | start / busy     | in_mode, in_request_bytes, in_pointer
//  result   | out_strobe       | out_status, out_block_address, out_block_bytes,
//           |                  | out_used_bytes, out_object_count
//  config   | cfg_we           | cfg_wdata (heap base)
//
// One list node is visited per cycle over the RAM read port. Allocate walks the list to
// the first free node that fits and, when it splits that node, scans for an unused slot
// for the remainder (the slot scan covers up to NODE_COUNT slots). Free walks the list
// twice (check pass, then commit pass) and then coalesces; a free that finds no node or
// an already free one ends after the check pass. Oversize and below-base requests skip
// the walk. The result strobe comes in the last busy cycle, lasts one cycle and cannot
// be stalled. Reset runs a clearing pass over the NODE_COUNT node RAM entries, busy high.
module first_fit_heap_allocator_core
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_pointer,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [27:0] out_block_bytes,
  output logic [31:0] out_used_bytes,
  output logic [10:0] out_object_count,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [7:0] {
    S_CLR     = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_AL_WALK = 8'b0000_0100,
    S_AL_SCAN = 8'b0000_1000,
    S_AL_FIN  = 8'b0001_0000,
    S_FR_WALK = 8'b0010_0000,
    S_FR_COAL = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [UNITS_W-1:0] u_r, u_nxt;
  logic [31:0]        ptr_r, ptr_nxt;
  logic               pass_r, pass_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [IDX_W-1:0]   p_idx_r, p_idx_nxt;
  node_t              p_data_r, p_data_nxt;
  logic               p_dirty_r, p_dirty_nxt;
  logic [IDX_W-1:0]   f_idx_r, f_idx_nxt;
  node_t              f_data_r, f_data_nxt;
  logic               from_reg_r, from_reg_nxt;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [31:0]        used_r, used_nxt;
  logic [10:0]        live_r, live_nxt;
  logic [31:0]        base_r;
  logic [2:0]         st_r, st_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [27:0]        bytes_r, bytes_nxt;

  // node RAM ports
  logic             we;
  logic [IDX_W-1:0] waddr;
  node_t            wdata;
  logic [IDX_W-1:0] raddr;
  node_t            rdata;

  ffha_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // current node seen by the walk
  node_t              nd;
  logic [LINK_W-1:0]  nxt_link;
  logic               nxt_end;
  logic [UNITS_W:0]   msum;
  logic               merge_ok;
  node_t              p_merged;
  logic               hit;
  logic [32:0]        need;
  logic [UNITS_W-1:0] need_u;
  logic [32:0]        used_add;
  logic [31:0]        used_inc;
  logic [10:0]        live_inc;
  logic [10:0]        live_dec;
  logic [27:0]        sz;
  logic [31:0]        used_dec;
  node_t              clr_word;

  always_comb begin
    nd       = from_reg_r ? f_data_r : rdata;
    nxt_link = next_of(nd.link);
    nxt_end  = (nxt_link == SENTINEL);
    msum     = {1'b0, p_data_r.units} + {1'b0, nd.units};
    merge_ok = (cur_r != '0) && nd.is_free && p_data_r.is_free &&
               (msum <= {1'b0, MAX_UNITS});
    p_merged       = p_data_r;
    p_merged.units = msum[UNITS_W-1:0];
    p_merged.link  = nd.link;
    hit      = ((base_r + {2'b00, nd.offset, 2'b00}) == ptr_r);
    // request rounded up to 4-byte units
    need     = ({1'b0, in_request_bytes} + 33'd3) >> 2;
    need_u   = (need == '0) ? UNITS_W'(1) : need[UNITS_W-1:0];
    used_add = {1'b0, used_r} + {5'b00000, u_r, 2'b00};
    used_inc = used_add[32] ? 32'hFFFF_FFFF : used_add[31:0];
    live_inc = (live_r == 11'h7FF) ? live_r : live_r + 11'd1;
    live_dec = (live_r == '0) ? live_r : live_r - 11'd1;
    sz       = {nd.units, 2'b00};
    used_dec = (used_r >= {4'b0000, sz}) ? used_r - {4'b0000, sz} : 32'd0;
    clr_word = '0;
    if (clr_r == '0) begin
      clr_word.is_free = 1'b1;
      clr_word.units   = MAX_UNITS;
      clr_word.link    = SENTINEL;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    u_nxt        = u_r;
    ptr_nxt      = ptr_r;
    pass_nxt     = pass_r;
    cur_nxt      = cur_r;
    step_nxt     = step_r;
    p_idx_nxt    = p_idx_r;
    p_data_nxt   = p_data_r;
    p_dirty_nxt  = p_dirty_r;
    f_idx_nxt    = f_idx_r;
    f_data_nxt   = f_data_r;
    from_reg_nxt = 1'b0;
    scan_nxt     = scan_r;
    used_nxt     = used_r;
    live_nxt     = live_r;
    st_nxt       = st_r;
    addr_nxt     = addr_r;
    bytes_nxt    = bytes_r;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    raddr        = '0;

    unique case (state_r)
      // reset clearing pass
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = clr_word;
        if (clr_r == IDX_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          addr_nxt  = '0;
          bytes_nxt = '0;
          cur_nxt   = '0;
          step_nxt  = '0;
          if (!in_mode) begin
            if (need > {7'd0, MAX_UNITS}) begin
              st_nxt    = ST_NO_FIT;
              state_nxt = S_DONE;
            end else begin
              u_nxt     = need_u;
              state_nxt = S_AL_WALK;
            end
          end else begin
            if (in_pointer < base_r) begin
              st_nxt    = ST_BELOW_BASE;
              state_nxt = S_DONE;
            end else begin
              ptr_nxt     = in_pointer;
              pass_nxt    = 1'b0;
              p_dirty_nxt = 1'b0;
              state_nxt   = S_FR_WALK;
            end
          end
        end
      end

      // first free node that fits
      S_AL_WALK: begin
        if (nd.is_free && nd.units >= u_r) begin
          f_idx_nxt  = cur_r;
          f_data_nxt = nd;
          if (nd.units > u_r) begin
            scan_nxt  = '0;
            state_nxt = S_AL_SCAN;
          end else begin
            we            = 1'b1;
            waddr         = cur_r;
            wdata         = nd;
            wdata.is_free = 1'b0;
            used_nxt      = used_inc;
            live_nxt      = live_inc;
            st_nxt        = ST_OK;
            addr_nxt      = base_r + {2'b00, nd.offset, 2'b00};
            bytes_nxt     = {u_r, 2'b00};
            state_nxt     = S_DONE;
          end
        end else if (nxt_end || step_r == STEP_W'(NODE_COUNT - 1)) begin
          st_nxt    = ST_NO_FIT;
          state_nxt = S_DONE;
        end else begin
          cur_nxt  = nxt_link[IDX_W-1:0];
          raddr    = nxt_link[IDX_W-1:0];
          step_nxt = step_r + 1'b1;
        end
      end

      // lowest unused slot for the split remainder
      S_AL_SCAN: begin
        raddr = scan_r + 1'b1;
        if (nd.units == '0) begin
          we            = 1'b1;
          waddr         = scan_r;
          wdata.offset  = f_data_r.offset + OFF_W'(u_r);
          wdata.is_free = 1'b1;
          wdata.units   = f_data_r.units - u_r;
          wdata.link    = f_data_r.link;
          state_nxt     = S_AL_FIN;
        end else if (scan_r == IDX_W'(NODE_COUNT - 1)) begin
          st_nxt    = ST_NO_SLOT;
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // shrink the chosen node and link in the remainder
      S_AL_FIN: begin
        we            = 1'b1;
        waddr         = f_idx_r;
        wdata.offset  = f_data_r.offset;
        wdata.is_free = 1'b0;
        wdata.units   = u_r;
        wdata.link    = LINK_W'(scan_r);
        used_nxt      = used_inc;
        live_nxt      = live_inc;
        st_nxt        = ST_OK;
        addr_nxt      = base_r + {2'b00, f_data_r.offset, 2'b00};
        bytes_nxt     = {u_r, 2'b00};
        state_nxt     = S_DONE;
      end

      // find the node, merging free pairs; pass 0 only checks, pass 1 writes
      S_FR_WALK: begin
        if (hit) begin
          if (!pass_r) begin
            if (nd.is_free) begin
              st_nxt    = ST_ALREADY_FREE;
              state_nxt = S_DONE;
            end else begin
              pass_nxt    = 1'b1;
              cur_nxt     = '0;
              step_nxt    = '0;
              p_dirty_nxt = 1'b0;
            end
          end else begin
            we                 = 1'b1;
            waddr              = cur_r;
            wdata              = nd;
            wdata.is_free      = 1'b1;
            f_data_nxt         = nd;
            f_data_nxt.is_free = 1'b1;
            from_reg_nxt       = 1'b1;
            used_nxt           = used_dec;
            live_nxt           = live_dec;
            st_nxt             = ST_OK;
            bytes_nxt          = sz;
            step_nxt           = '0;
            state_nxt          = S_FR_COAL;
          end
        end else begin
          if (merge_ok) begin
            p_data_nxt  = p_merged;
            p_dirty_nxt = 1'b1;
            if (pass_r) begin
              we    = 1'b1;
              waddr = cur_r;
            end
          end else begin
            if (pass_r && p_dirty_r) begin
              we    = 1'b1;
              waddr = p_idx_r;
              wdata = p_data_r;
            end
            p_idx_nxt   = cur_r;
            p_data_nxt  = nd;
            p_dirty_nxt = 1'b0;
          end
          if (nxt_end || step_r == STEP_W'(BOUND - 1)) begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            cur_nxt  = nxt_link[IDX_W-1:0];
            raddr    = nxt_link[IDX_W-1:0];
            step_nxt = step_r + 1'b1;
          end
        end
      end

      // coalesce free nodes after the freed one, never into the last node
      S_FR_COAL: begin
        if (step_r == STEP_W'(BOUND) || nxt_end || !nd.is_free) begin
          if (p_dirty_r) begin
            we    = 1'b1;
            waddr = p_idx_r;
            wdata = p_data_r;
          end
          p_dirty_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
          if (merge_ok) begin
            p_data_nxt  = p_merged;
            p_dirty_nxt = 1'b1;
            we          = 1'b1;
            waddr       = cur_r;
          end else begin
            if (p_dirty_r) begin
              we    = 1'b1;
              waddr = p_idx_r;
              wdata = p_data_r;
            end
            p_idx_nxt   = cur_r;
            p_data_nxt  = nd;
            p_dirty_nxt = 1'b0;
          end
          cur_nxt = nxt_link[IDX_W-1:0];
          raddr   = nxt_link[IDX_W-1:0];
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      used_r     <= '0;
      live_r     <= '0;
      p_dirty_r  <= 1'b0;
      from_reg_r <= 1'b0;
      pass_r     <= 1'b0;
      step_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      used_r     <= used_nxt;
      live_r     <= live_nxt;
      p_dirty_r  <= p_dirty_nxt;
      from_reg_r <= from_reg_nxt;
      pass_r     <= pass_nxt;
      step_r     <= step_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    u_r      <= u_nxt;
    ptr_r    <= ptr_nxt;
    cur_r    <= cur_nxt;
    p_idx_r  <= p_idx_nxt;
    p_data_r <= p_data_nxt;
    f_idx_r  <= f_idx_nxt;
    f_data_r <= f_data_nxt;
    scan_r   <= scan_nxt;
    st_r     <= st_nxt;
    addr_r   <= addr_nxt;
    bytes_r  <= bytes_nxt;
  end

  // heap base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // outputs
  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = (state_r == S_DONE);
  assign out_status        = st_r;
  assign out_block_address = addr_r;
  assign out_block_bytes   = bytes_r;
  assign out_used_bytes    = used_r;
  assign out_object_count  = live_r;

endmodule

FILE: verif/first_fit_heap_allocator_core_checker.sv
// Checker for the first-fit heap allocator core: keeps its own node table,
// predicts every result and compares it with the strobed result.
// Depends on ffha_pkg for status codes and table sizes.
module first_fit_heap_allocator_core_checker
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_pointer,
  input  logic        out_strobe,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_block_address,
  input  logic [27:0] out_block_bytes,
  input  logic [31:0] out_used_bytes,
  input  logic [10:0] out_object_count,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] address;
    logic [27:0] bytes;
    logic [31:0] used;
    logic [10:0] objects;
  } heap_result_t;

  // shadow heap state
  logic [31:0]        base_addr;
  logic [OFF_W-1:0]   tbl_off  [NODE_COUNT];
  bit                 tbl_free [NODE_COUNT];
  logic [UNITS_W-1:0] tbl_units[NODE_COUNT];
  int                 tbl_link [NODE_COUNT];
  logic [31:0]        used_sum;
  int                 live_cnt;

  heap_result_t expected_results[$];

  function automatic int follow(int i);
    return (tbl_link[i] >= NODE_COUNT) ? NODE_COUNT : tbl_link[i];
  endfunction

  function automatic logic [31:0] addr_of_node(int i);
    return base_addr + {2'b00, tbl_off[i], 2'b00};
  endfunction

  function automatic void clear_heap();
    for (int k = 0; k < NODE_COUNT; k++) begin
      tbl_off[k] = '0;
      tbl_free[k] = 0;
      tbl_units[k] = '0;
      tbl_link[k] = 0;
    end
    tbl_free[0] = 1;
    tbl_units[0] = MAX_UNITS;
    tbl_link[0] = NODE_COUNT;
    used_sum = '0;
    live_cnt = 0;
    base_addr = '0;
  endfunction

  // fold cur into prev when both are free and the sum still fits
  function automatic bit join_pair(int prev, int cur);
    if (cur == 0 || !tbl_free[cur] || !tbl_free[prev]) return 0;
    if ({1'b0, tbl_units[cur]} + {1'b0, tbl_units[prev]} > {1'b0, MAX_UNITS}) return 0;
    tbl_units[prev] = tbl_units[prev] + tbl_units[cur];
    tbl_link[prev] = tbl_link[cur];
    tbl_off[cur] = '0;
    tbl_free[cur] = 0;
    tbl_units[cur] = '0;
    tbl_link[cur] = 0;
    return 1;
  endfunction

  function automatic heap_result_t predict_alloc(logic [31:0] req);
    heap_result_t r;
    logic [33:0] need;
    logic [UNITS_W-1:0] u;
    logic [33:0] total;
    int i, slot;
    bit found, have_slot;
    r = '0;
    i = 0;
    found = 0;
    have_slot = 0;
    slot = 0;
    need = ({2'b00, req} + 34'd3) >> 2;
    if (need == 0) need = 1;
    if (need > {8'd0, MAX_UNITS}) begin
      r.status = ST_NO_FIT;
    end else begin
      u = need[UNITS_W-1:0];
      // first fit walk
      for (int steps = 0; steps < NODE_COUNT; steps++) begin
        if (tbl_free[i] && tbl_units[i] >= u) begin
          found = 1;
          break;
        end
        if (follow(i) >= NODE_COUNT) break;
        i = follow(i);
      end
      if (!found) begin
        r.status = ST_NO_FIT;
      end else begin
        if (tbl_units[i] > u) begin
          for (slot = 0; slot < NODE_COUNT; slot++)
            if (tbl_units[slot] == 0) begin
              have_slot = 1;
              break;
            end
        end
        if (tbl_units[i] > u && !have_slot) begin
          r.status = ST_NO_SLOT;
        end else begin
          // split the remainder into the spare slot
          if (tbl_units[i] > u) begin
            tbl_off[slot] = tbl_off[i] + OFF_W'(u);
            tbl_free[slot] = 1;
            tbl_units[slot] = tbl_units[i] - u;
            tbl_link[slot] = tbl_link[i];
            tbl_link[i] = slot;
            tbl_units[i] = u;
          end
          tbl_free[i] = 0;
          total = {2'b00, used_sum} + {6'd0, u, 2'b00};
          used_sum = (total > 34'hFFFFFFFF) ? 32'hFFFFFFFF : total[31:0];
          if (live_cnt < 2047) live_cnt++;
          r.status = ST_OK;
          r.address = addr_of_node(i);
          r.bytes = {u, 2'b00};
        end
      end
    end
    r.used = used_sum;
    r.objects = live_cnt[10:0];
    return r;
  endfunction

  function automatic heap_result_t predict_release(logic [31:0] ptr);
    heap_result_t r;
    logic [OFF_W-1:0]   sv_off  [NODE_COUNT];
    bit                 sv_free [NODE_COUNT];
    logic [UNITS_W-1:0] sv_units[NODE_COUNT];
    int                 sv_link [NODE_COUNT];
    logic [27:0] sz;
    int cur, prev, steps;
    bit found;
    r = '0;
    cur = 0;
    prev = 0;
    steps = 0;
    found = 0;
    if (ptr < base_addr) begin
      r.status = ST_BELOW_BASE;
    end else begin
      sv_off = tbl_off;
      sv_free = tbl_free;
      sv_units = tbl_units;
      sv_link = tbl_link;
      // search walk, merging free pairs on the way
      while (steps < BOUND && cur < NODE_COUNT) begin
        steps++;
        if (addr_of_node(cur) == ptr) begin
          found = 1;
          break;
        end
        if (join_pair(prev, cur)) begin
          cur = follow(prev);
          continue;
        end
        prev = cur;
        cur = follow(cur);
      end
      if (!found || tbl_free[cur]) begin
        // failed free leaves the table untouched
        tbl_off = sv_off;
        tbl_free = sv_free;
        tbl_units = sv_units;
        tbl_link = sv_link;
        r.status = found ? ST_ALREADY_FREE : ST_NOT_FOUND;
      end else begin
        tbl_free[cur] = 1;
        sz = {tbl_units[cur], 2'b00};
        used_sum = (used_sum >= {4'd0, sz}) ? used_sum - {4'd0, sz} : '0;
        if (live_cnt > 0) live_cnt--;
        r.status = ST_OK;
        r.bytes = sz;
        // coalesce forward, never into the last node
        steps = 0;
        while (steps < BOUND && cur < NODE_COUNT && follow(cur) < NODE_COUNT && tbl_free[cur])
        begin
          steps++;
          if (join_pair(prev, cur)) begin
            cur = follow(prev);
            continue;
          end
          prev = cur;
          cur = follow(cur);
        end
      end
    end
    r.used = used_sum;
    r.objects = live_cnt[10:0];
    return r;
  endfunction

  assign awaiting = expected_results.size();

  // compare first, then take the new request of the same edge
  always @(posedge clk) begin
    heap_result_t got, want;
    if (!rst_n) begin
      clear_heap();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_strobe) begin
        got = '{out_status, out_block_address, out_block_bytes, out_used_bytes,
                out_object_count};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: status %0d addr %h bytes %h", $realtime,
                     got.status, got.address, got.bytes);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch: exp st %0d addr %h bytes %h used %h objs %0d",
                       $realtime, want.status, want.address, want.bytes, want.used,
                       want.objects);
              $display("  got st %0d addr %h bytes %h used %h objs %0d",
                       got.status, got.address, got.bytes, got.used, got.objects);
            end
          end
        end
      end
      if (cfg_we) base_addr = cfg_wdata;
      if (start && !busy) begin
        // mode high is a free request
        if (in_mode) expected_results.push_back(predict_release(in_pointer));
        else expected_results.push_back(predict_alloc(in_request_bytes));
      end
    end
  end

endmodule

FILE: verif/first_fit_heap_allocator_core_test.sv
// Testbench top for the first-fit heap allocator core: makes requests and
// heap base writes, and gives the verdict from the checker's counts.
// Depends on ffha_pkg, the core RTL and first_fit_heap_allocator_core_checker.
module first_fit_heap_allocator_core_test
  import ffha_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam int   CYCLE_LIMIT = 40_000_000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_mode = MODE_ALLOC;
  logic [31:0] in_request_bytes = '0;
  logic [31:0] in_pointer = '0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [31:0] out_block_address;
  logic [27:0] out_block_bytes;
  logic [31:0] out_used_bytes;
  logic [10:0] out_object_count;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  int          mismatches;
  int          awaiting;

  logic [31:0] heap_start = '0;
  logic [31:0] live_blocks[$];
  logic [31:0] freed_blocks[$];
  logic        sent_modes[$];
  int          status_seen[6];
  int          cycles = 0;
  bit          quiet = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  first_fit_heap_allocator_core u_top (.*);

  first_fit_heap_allocator_core_checker u_checker (.*);

  // track accepted requests and the blocks handed out
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator_core_test: done, errors");
      $finish;
    end
    if (rst_n && out_strobe && sent_modes.size() != 0) begin
      if (sent_modes.pop_front() == MODE_ALLOC && out_status == ST_OK)
        live_blocks.push_back(out_block_address);
      if (out_status < 6) status_seen[out_status]++;
    end
    if (rst_n && start && !busy) sent_modes.push_back(in_mode);
  end

  // one request, called and returning at a falling edge
  task automatic send_request(logic mode, logic [31:0] bytes, logic [31:0] ptr);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    start = 0;
    repeat (gap) @(negedge clk);
    in_mode = mode;
    in_request_bytes = bytes;
    in_pointer = ptr;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  task automatic wait_idle();
    start = 0;
    while (awaiting != 0 || sent_modes.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // heap base change, live addresses move with it
  task automatic set_heap_base(logic [31:0] value);
    wait_idle();
    cfg_we = 1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
    cfg_wdata = $urandom;
    foreach (live_blocks[k]) live_blocks[k] = live_blocks[k] - heap_start + value;
    foreach (freed_blocks[k]) freed_blocks[k] = freed_blocks[k] - heap_start + value;
    heap_start = value;
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 64);
    if (r < 90) return $urandom_range(65, 4096);
    if (r < 98) return $urandom_range(4097, 1 << 20);
    return $urandom;
  endfunction

  task automatic release_block(logic [31:0] a);
    send_request(MODE_FREE, $urandom, a);
    freed_blocks.push_back(a);
    if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
  endtask

  // mostly real alloc/free traffic, some malformed frees
  task automatic random_traffic(int n);
    int r, k;
    logic [31:0] a;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 55 || (r < 90 && live_blocks.size() == 0)) begin
        send_request(MODE_ALLOC, pick_size(), $urandom);
      end else if (r < 90) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        release_block(a);
      end else begin
        case ($urandom_range(0, 3))
          0: a = (heap_start != 0) ? $urandom_range(0, heap_start - 1) : $urandom;
          1: a = (freed_blocks.size() != 0) ?
                 freed_blocks[$urandom_range(0, freed_blocks.size() - 1)] : $urandom;
          2: a = (live_blocks.size() != 0) ?
                 live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 4 : $urandom;
          default: a = $urandom;
        endcase
        send_request(MODE_FREE, $urandom, a);
      end
    end
  endtask

  task automatic release_all_in_order();
    logic [31:0] a;
    wait_idle();
    live_blocks.sort() with (item - heap_start);
    while (live_blocks.size() != 0) begin
      a = live_blocks.pop_front();
      release_block(a);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1;

    // directed: sizes at the edges and every failure status but no_slot
    set_heap_base(32'h0000_1000);
    send_request(MODE_ALLOC, 32'd0, '0);
    send_request(MODE_ALLOC, 32'd1, '1);
    send_request(MODE_ALLOC, 32'd3, '0);
    send_request(MODE_ALLOC, 32'd4, '1);
    send_request(MODE_ALLOC, 32'd5, '0);
    send_request(MODE_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(MODE_ALLOC, 32'h0FFF_FFFD, '1);
    wait_idle();
    send_request(MODE_FREE, '0, heap_start);
    send_request(MODE_FREE, '1, heap_start);
    send_request(MODE_FREE, '0, 32'h0);
    send_request(MODE_FREE, '1, heap_start + 2);
    send_request(MODE_FREE, '0, 32'hFFFF_FFFF);
    wait_idle();
    void'(live_blocks.pop_front());
    release_all_in_order();
    send_request(MODE_ALLOC, 32'h0FFF_FFFC, '0);
    release_all_in_order();
    send_request(MODE_ALLOC, 32'h0FFF_FFFC, '0);
    release_all_in_order();

    // wrapping addresses near the top of the space
    set_heap_base(32'hFFFF_FFF0);
    random_traffic(200);
    set_heap_base(32'hFFFF_FFFF);
    random_traffic(80);
    release_all_in_order();

    // fill every node slot so a split has nowhere to go
    set_heap_base($urandom_range(0, 32'h3FFF_FFFF) << 2);
    for (int j = 0; j < 1030; j++) send_request(MODE_ALLOC, $urandom_range(0, 8), $urandom);

    // traffic over a crowded table, then without gaps
    set_heap_base(32'h0);
    random_traffic(200);
    quiet = 1;
    random_traffic(150);

    // drain
    wait_idle();
    $display("covered %0d requests: ok %0d, no_fit %0d, no_slot %0d, below_base %0d,",
             status_seen.sum(), status_seen[ST_OK], status_seen[ST_NO_FIT],
             status_seen[ST_NO_SLOT], status_seen[ST_BELOW_BASE]);
    $display("  not_found %0d, already_free %0d; mismatches %0d",
             status_seen[ST_NOT_FOUND], status_seen[ST_ALREADY_FREE], mismatches);
    if (mismatches == 0 && awaiting == 0)
      $display("first_fit_heap_allocator_core_test: done, clean");
    else
      $display("first_fit_heap_allocator_core_test: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator_core.sv
verif/first_fit_heap_allocator_core_checker.sv
verif/first_fit_heap_allocator_core_test.sv
